### design/bmu_pkg.sv
// Shared constants, codes and types for the bitmap integer upscaler.
// No dependencies; imported by the interfaces, the line buffer, the top level and the sim files.
package bmu_pkg;

  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int SCALE_LIMIT       = 99;

  localparam int SCALE_W  = 7;
  localparam int RWIDTH_W = 11;
  localparam int HEIGHT_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PIX_W    = 24;

  // request codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_WRITTEN  = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_GIVEN    = 2'd2;
  localparam logic [1:0] ST_NO_ROW   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  // line buffer port strobes
  typedef struct packed {
    logic we;
    logic re;
  } bmu_mem_ctl_t;

endpackage

### design/bmu_in_if.sv
// Input word channel: valid/ready plus one write or request word.
// Depends on bmu_pkg.
interface bmu_in_if import bmu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;

  modport source (output valid, func, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, func, blue_in, green_in, red_in, output ready);
endinterface

### design/bmu_out_if.sv
// Result word channel: valid/ready plus status, pixel and row/image marks.
// Depends on bmu_pkg.
interface bmu_out_if import bmu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       row_end;
  logic [1:0] pad_bytes;
  logic       image_end;

  modport source (output valid, status, blue_out, green_out, red_out,
                  row_end, pad_bytes, image_end, input ready);
  modport sink   (input valid, status, blue_out, green_out, red_out,
                  row_end, pad_bytes, image_end, output ready);
endinterface

### design/bmu_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on bmu_pkg.
interface bmu_cfg_if import bmu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/bitmap_integer_upscale.sv
// Nearest-neighbor integer upscaler for 24-bit pixels, line-buffer based.
// Pipeline: 2 register stages, stage 1 (buffer read) then the output register.
// Throughput: one word per cycle unless the result side stalls; each word costs at most
//   one counter update and one line buffer access (single write port, single read port).
// Reset (synchronous, rst_n low): registers to 1, counters and flags to zero,
//   pipeline empty. Line buffer contents stay undefined; there is no clearing pass.
// Depends on bmu_pkg, bmu_in_if, bmu_out_if, bmu_cfg_if, bmu_line_buf.
module bitmap_integer_upscale import bmu_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  bmu_in_if.sink    in_ch,
  bmu_out_if.source out_ch,
  bmu_cfg_if.sink   cfg_ch
);

  // address bits and counter bits (counter must hold MAX_WIDTH itself)
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam logic [CW-1:0] MAX_W_C = CW'(MAX_WIDTH);
  localparam logic [SCALE_W-1:0] SCALE_MAX_C = SCALE_W'(SCALE_LIMIT);

  // ---------------------------------------------------------------
  // configuration registers; the port never stalls
  // ---------------------------------------------------------------
  logic [SCALE_W-1:0]  scale_r;
  logic [RWIDTH_W-1:0] width_r;
  logic [HEIGHT_W-1:0] height_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_W'(1);
      width_r  <= RWIDTH_W'(1);
      height_r <= HEIGHT_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SCALE:  scale_r  <= cfg_ch.data[SCALE_W-1:0];
        REG_WIDTH:  width_r  <= cfg_ch.data[RWIDTH_W-1:0];
        REG_HEIGHT: height_r <= cfg_ch.data[HEIGHT_W-1:0];
        default:    ;  // unknown index, dropped
      endcase
    end
  end

  // effective limits: zero acts as one, oversize clamps
  logic [SCALE_W-1:0]  s_eff;
  logic [CW-1:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [1:0]          pad_eff;

  always_comb begin
    if (scale_r == '0)              s_eff = SCALE_W'(1);
    else if (scale_r > SCALE_MAX_C) s_eff = SCALE_MAX_C;
    else                            s_eff = scale_r;

    if (width_r == '0)                       w_eff = CW'(1);
    else if (32'(width_r) > 32'(MAX_WIDTH))  w_eff = MAX_W_C;
    else                                     w_eff = CW'(width_r);

    h_eff = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  end

  // (w*s) mod 4 only needs the low two bits of each factor
  logic [3:0] pad_prod;
  assign pad_prod = 4'(2'(w_eff)) * 4'(s_eff[1:0]);
  assign pad_eff  = pad_prod[1:0];

  // ---------------------------------------------------------------
  // handshake: stage 1 (buffer read) feeds the output register
  // ---------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_move, in_fire, out_fire;

  assign s1_move      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_valid_r && out_ch.ready;

  // ---------------------------------------------------------------
  // row counters: read-modify-write around the line buffer
  // ---------------------------------------------------------------
  logic [CW-1:0]       write_col_r, write_col_nxt;
  logic                row_ready_r, row_ready_nxt;
  logic [CW-1:0]       read_col_r,  read_col_nxt;
  logic [SCALE_W-1:0]  hcopy_r,     hcopy_nxt;
  logic [SCALE_W-1:0]  vcopy_r,     vcopy_nxt;
  logic [HEIGHT_W-1:0] row_idx_r,   row_idx_nxt;

  logic [CW-1:0]       wcol_inc, rcol_inc;
  logic [SCALE_W-1:0]  hcopy_inc, vcopy_inc;
  logic [HEIGHT_W-1:0] row_inc;

  bmu_mem_ctl_t mem_ctl;
  logic [1:0]   st_status;
  logic         st_row_end;
  logic [1:0]   st_pad;
  logic         st_img_end;

  assign wcol_inc  = write_col_r + CW'(1);
  assign rcol_inc  = read_col_r + CW'(1);
  assign hcopy_inc = hcopy_r + SCALE_W'(1);
  assign vcopy_inc = vcopy_r + SCALE_W'(1);
  assign row_inc   = row_idx_r + HEIGHT_W'(1);

  always_comb begin
    write_col_nxt = write_col_r;
    row_ready_nxt = row_ready_r;
    read_col_nxt  = read_col_r;
    hcopy_nxt     = hcopy_r;
    vcopy_nxt     = vcopy_r;
    row_idx_nxt   = row_idx_r;
    mem_ctl       = '0;
    st_status     = ST_WRITTEN;
    st_row_end    = 1'b0;
    st_pad        = 2'd0;
    st_img_end    = 1'b0;

    if (in_fire) begin
      if (in_ch.func == FUNC_WRITE) begin
        if (row_ready_r) begin
          st_status = ST_REJECTED;   // row still being replayed
        end else begin
          mem_ctl.we = (write_col_r < MAX_W_C);
          if (wcol_inc >= w_eff) begin
            // row complete: arm the replay
            write_col_nxt = '0;
            row_ready_nxt = 1'b1;
            read_col_nxt  = '0;
            hcopy_nxt     = '0;
            vcopy_nxt     = '0;
          end else begin
            write_col_nxt = wcol_inc;
          end
        end
      end else if (!row_ready_r) begin
        st_status = ST_NO_ROW;
      end else begin
        st_status  = ST_GIVEN;
        mem_ctl.re = 1'b1;
        // limits compared as reached-or-passed so a lowered register ends early
        if (hcopy_inc >= s_eff) begin
          hcopy_nxt = '0;
          if (rcol_inc >= w_eff) begin
            read_col_nxt = '0;
            st_row_end   = 1'b1;
            st_pad       = pad_eff;
            if (vcopy_inc >= s_eff) begin
              vcopy_nxt     = '0;
              row_ready_nxt = 1'b0;   // free the buffer for the next input row
              if (row_inc >= h_eff) begin
                row_idx_nxt = '0;
                st_img_end  = 1'b1;
              end else begin
                row_idx_nxt = row_inc;
              end
            end else begin
              vcopy_nxt = vcopy_inc;
            end
          end else begin
            read_col_nxt = rcol_inc;
          end
        end else begin
          hcopy_nxt = hcopy_inc;
        end
      end
    end
  end

  // writes only happen with no row ready and reads only with one, so a
  // read never meets a write in the same cycle; no forwarding needed
  logic [PIX_W-1:0] buf_rdata;

  bmu_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_buf (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (write_col_r[AW-1:0]),
    .wdata ({in_ch.red_in, in_ch.green_in, in_ch.blue_in}),
    .raddr (read_col_r[AW-1:0]),
    .rdata (buf_rdata)
  );

  // stage 1 side info, lined up with the buffer read data
  logic [1:0] s1_status_r;
  logic       s1_row_end_r;
  logic [1:0] s1_pad_r;
  logic       s1_img_end_r;

  // output register
  logic [1:0]       out_status_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_row_end_r;
  logic [1:0]       out_pad_r;
  logic             out_img_end_r;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_move ? 1'b1 : (out_fire ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_col_r <= '0;
      row_ready_r <= 1'b0;
      read_col_r  <= '0;
      hcopy_r     <= '0;
      vcopy_r     <= '0;
      row_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      write_col_r <= write_col_nxt;
      row_ready_r <= row_ready_nxt;
      read_col_r  <= read_col_nxt;
      hcopy_r     <= hcopy_nxt;
      vcopy_r     <= vcopy_nxt;
      row_idx_r   <= row_idx_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r  <= st_status;
      s1_row_end_r <= st_row_end;
      s1_pad_r     <= st_pad;
      s1_img_end_r <= st_img_end;
    end
    if (s1_move) begin
      out_status_r  <= s1_status_r;
      out_pix_r     <= (s1_status_r == ST_GIVEN) ? buf_rdata : '0;
      out_row_end_r <= s1_row_end_r;
      out_pad_r     <= s1_pad_r;
      out_img_end_r <= s1_img_end_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.blue_out  = out_pix_r[7:0];
  assign out_ch.green_out = out_pix_r[15:8];
  assign out_ch.red_out   = out_pix_r[23:16];
  assign out_ch.row_end   = out_row_end_r;
  assign out_ch.pad_bytes = out_pad_r;
  assign out_ch.image_end = out_img_end_r;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.we && mem_ctl.re))
    else $error("line buffer read and write in the same cycle");

  a_row_end_given: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_row_end_r || out_pad_r != 2'd0)) |-> (out_status_r == ST_GIVEN))
    else $error("row mark on a word that carries no pixel");

  a_img_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_img_end_r) |-> out_row_end_r)
    else $error("image end without row end");

  a_replay_freed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && st_img_end) |=> !row_ready_r)
    else $error("buffer still held after the last row of the image");

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (hcopy_r < SCALE_MAX_C) && (vcopy_r < SCALE_MAX_C))
    else $error("copy counter past the scale limit");

endmodule

### design/bmu_line_buf.sv
// Line buffer: one-write one-read synchronous RAM, registered read data.
// Depends on bmu_pkg for the strobe struct.
module bmu_line_buf import bmu_pkg::*; #(
  parameter int DEPTH = DEFAULT_MAX_WIDTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  bmu_mem_ctl_t      ctl,
  input  logic [AW-1:0]     waddr,
  input  logic [PIX_W-1:0]  wdata,
  input  logic [AW-1:0]     raddr,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) mem[waddr] <= wdata;
    if (ctl.re) rdata_r <= mem[raddr];  // held while no read issued
  end

  assign rdata = rdata_r;

endmodule

### sim/bmu_upscale_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the bitmap upscaler: watches the word, result and register channels.
// Depends on bmu_pkg and the three channel interfaces.
module bmu_upscale_checker import bmu_pkg::*; #(
  parameter int MAX_W = DEFAULT_MAX_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  bmu_in_if    in_mon,
  bmu_out_if   out_mon,
  bmu_cfg_if   cfg_mon,
  output int   mismatches,
  output int   pending,
  output logic row_held,
  output int   filled_cols,
  output int   pixels_checked,
  output int   image_ends
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       image_end;
  } upscale_word_t;

  logic [SCALE_W-1:0]  scale_q;
  logic [RWIDTH_W-1:0] width_q;
  logic [HEIGHT_W-1:0] height_q;

  logic [PIX_W-1:0] line_pix [MAX_W];
  int wr_col, rd_col, h_copy, v_copy, row_num;

  upscale_word_t expected_words[$];

  // Next result of the upscaler for one accepted word; advances the mirrored state.
  function automatic upscale_word_t upscale_step(logic func, logic [7:0] blue,
                                                 logic [7:0] green, logic [7:0] red);
    int w, s, h;
    upscale_word_t res;
    logic [PIX_W-1:0] pix;
    w = (width_q == 0) ? 1 : ((width_q > MAX_W) ? MAX_W : int'(width_q));
    s = (scale_q == 0) ? 1 : ((scale_q > SCALE_LIMIT) ? SCALE_LIMIT : int'(scale_q));
    h = (height_q == 0) ? 1 : int'(height_q);
    res = '0;
    if (func == FUNC_WRITE) begin
      if (row_held) begin
        res.status = ST_REJECTED;
        return res;
      end
      line_pix[wr_col] = {red, green, blue};
      if (wr_col + 1 > filled_cols) filled_cols = wr_col + 1;
      wr_col++;
      if (wr_col >= w) begin
        wr_col   = 0;
        row_held = 1'b1;
        rd_col   = 0;
        h_copy   = 0;
        v_copy   = 0;
      end
      res.status = ST_WRITTEN;
      return res;
    end
    if (!row_held) begin
      res.status = ST_NO_ROW;
      return res;
    end
    pix        = line_pix[rd_col];
    res.status = ST_GIVEN;
    res.blue   = pix[7:0];
    res.green  = pix[15:8];
    res.red    = pix[23:16];
    h_copy++;
    if (h_copy >= s) begin
      h_copy = 0;
      rd_col++;
      if (rd_col >= w) begin
        rd_col        = 0;
        res.row_end   = 1'b1;
        res.pad_bytes = 2'((w * s) & 3);
        v_copy++;
        if (v_copy >= s) begin
          v_copy   = 0;
          row_held = 1'b0;
          row_num++;
          if (row_num >= h) begin
            row_num       = 0;
            res.image_end = 1'b1;
            image_ends++;
          end
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_word(upscale_word_t got);
    upscale_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("result word with none expected, status", '0, got.status);
      return;
    end
    want = expected_words.pop_front();
    if (got.status !== want.status)       report_mismatch("status", want.status, got.status);
    if (got.blue !== want.blue)           report_mismatch("blue_out", want.blue, got.blue);
    if (got.green !== want.green)         report_mismatch("green_out", want.green, got.green);
    if (got.red !== want.red)             report_mismatch("red_out", want.red, got.red);
    if (got.row_end !== want.row_end)     report_mismatch("row_end", want.row_end, got.row_end);
    if (got.pad_bytes !== want.pad_bytes)
      report_mismatch("pad_bytes", want.pad_bytes, got.pad_bytes);
    if (got.image_end !== want.image_end)
      report_mismatch("image_end", want.image_end, got.image_end);
    if (want.status == ST_GIVEN) pixels_checked++;
  endtask

  always @(posedge clk) begin
    upscale_word_t got;
    if (!rst_n) begin
      scale_q        = SCALE_W'(1);
      width_q        = RWIDTH_W'(1);
      height_q       = HEIGHT_W'(1);
      wr_col         = 0;
      rd_col         = 0;
      h_copy         = 0;
      v_copy         = 0;
      row_num        = 0;
      row_held       = 1'b0;
      filled_cols    = 0;
      mismatches     = 0;
      pixels_checked = 0;
      image_ends     = 0;
      expected_words.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_SCALE:  scale_q  = cfg_mon.data[SCALE_W-1:0];
          REG_WIDTH:  width_q  = cfg_mon.data[RWIDTH_W-1:0];
          REG_HEIGHT: height_q = cfg_mon.data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      // results leave before this edge's word can have produced one
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.status, out_mon.blue_out, out_mon.green_out, out_mon.red_out,
               out_mon.row_end, out_mon.pad_bytes, out_mon.image_end};
        check_word(got);
      end
      if (in_mon.valid && in_mon.ready)
        expected_words.push_back(upscale_step(in_mon.func, in_mon.blue_in,
                                              in_mon.green_in, in_mon.red_in));
    end
    pending = expected_words.size();
  end

endmodule

### sim/bitmap_integer_upscale_tb.sv
`timescale 1ns / 100ps
// Top of the upscaler bench: clock, reset, word/register stimulus and the verdict.
// Depends on bmu_pkg, the channel interfaces, bitmap_integer_upscale and bmu_upscale_checker.
module bitmap_integer_upscale_tb import bmu_pkg::*; ();

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 4;    // margin for a result to pass the two register stages
  localparam int LONG_HOLD     = 400;  // result side stall, long enough to back up the input

  logic clk;
  logic rst_n;

  bmu_in_if  in_ch ();
  bmu_out_if out_ch ();
  bmu_cfg_if cfg_ch ();

  int   mismatches;
  int   pending_words;
  logic row_held;
  int   filled_cols;
  int   pixels_checked;
  int   image_ends;

  // pacing: 0 no gaps, 1 occasional gaps, 2 gap drawn for every word
  int send_pace;
  int recv_pace;
  bit long_hold_req;
  int words_sent;
  int settings_used;
  int cycle_count;

  bitmap_integer_upscale DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bmu_upscale_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .mismatches     (mismatches),
    .pending        (pending_words),
    .row_held       (row_held),
    .filled_cols    (filled_cols),
    .pixels_checked (pixels_checked),
    .image_ends     (image_ends)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending_words);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int draw_gap(int pace);
    case (pace)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      default: return $urandom_range(0, 19);
    endcase
  endfunction

  // Result side: per word draws a stall, then takes the word. A long hold request
  // from the stimulus side replaces one draw with the LONG_HOLD stall.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        gap           = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        gap = draw_gap(recv_pace);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // Offer one word after a drawn gap; returns at the falling edge after acceptance
  // with valid still high, so back-to-back words keep valid up.
  task automatic send_word(logic func, logic [7:0] blue, logic [7:0] green, logic [7:0] red);
    int gap;
    gap = draw_gap(send_pace);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= func;
    in_ch.blue_in  <= blue;
    in_ch.green_in <= green;
    in_ch.red_in   <= red;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    words_sent++;
  endtask

  // Stop offering and wait for every expected result, plus the pipeline depth.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
  endtask

  // New settings, only with the block idle. A row still held while the width
  // grows past what was ever stored would read unwritten entries, so such a
  // row is read out first under the old settings.
  task automatic set_upscale(logic [CFG_DATA_W-1:0] scale_v, logic [CFG_DATA_W-1:0] width_v,
                             logic [CFG_DATA_W-1:0] height_v);
    int new_w;
    settle();
    new_w = (width_v[RWIDTH_W-1:0] == 0) ? 1 :
            ((width_v[RWIDTH_W-1:0] > DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH :
             int'(width_v[RWIDTH_W-1:0]));
    if (row_held && new_w > filled_cols) begin
      while (row_held)
        send_word(FUNC_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      settle();
    end
    write_reg(REG_SCALE, scale_v);
    write_reg(REG_WIDTH, width_v);
    write_reg(REG_HEIGHT, height_v);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed traffic: fill a row, then request its pixels. One word
  // in ten goes the other way, giving rejected writes and requests with no row.
  task automatic run_phase(int n_words);
    logic func;
    for (int i = 0; i < n_words; i++) begin
      if (i % 64 == 0) begin
        send_pace = $urandom_range(0, 2);
        recv_pace = $urandom_range(0, 2);
      end
      if ($urandom_range(0, 199) == 0) settle();
      func = row_held ? FUNC_READ : FUNC_WRITE;
      if ($urandom_range(0, 9) == 0) func = (func == FUNC_READ) ? FUNC_WRITE : FUNC_READ;
      send_word(func, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_WRITE;
    in_ch.blue_in  = '0;
    in_ch.green_in = '0;
    in_ch.red_in   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_SCALE;
    cfg_ch.data    = '0;
    send_pace      = 1;
    recv_pace      = 1;
    long_hold_req  = 1'b0;
    words_sent     = 0;
    settings_used  = 0;
    cycle_count    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, at reset settings (1x, one pixel wide, one row high):
    // request before any row, fill, write into a busy row, read back extremes.
    send_word(FUNC_READ,  8'h00, 8'h00, 8'h00);
    send_word(FUNC_WRITE, 8'h00, 8'h00, 8'h00);
    send_word(FUNC_WRITE, 8'hFF, 8'hFF, 8'hFF);
    send_word(FUNC_READ,  8'hFF, 8'hFF, 8'hFF);
    send_word(FUNC_WRITE, 8'hFF, 8'hFF, 8'hFF);
    send_word(FUNC_READ,  8'h00, 8'h00, 8'h00);
    send_word(FUNC_WRITE, 8'h5A, 8'hA5, 8'h3C);
    send_word(FUNC_READ,  8'h00, 8'h00, 8'h00);
    send_word(FUNC_READ,  8'h00, 8'h00, 8'h00);

    // 3x, two wide, two high: pad of 2 at row end
    set_upscale(16'd3, 16'd2, 16'd2);
    run_phase(60);
    // largest scale on a one-pixel row; the row is left mid-copy
    set_upscale(16'd99, 16'd1, 16'd1);
    run_phase(150);
    // zero scale, width and height act as one; the lowered scale ends that row at once
    set_upscale(16'h0080, 16'hF800, 16'h0000);
    run_phase(40);
    // wide row at 1x: pad 0
    set_upscale(16'd1, 16'd300, 16'd1);
    run_phase(400);
    // long result stall while words keep coming, input must back up
    set_upscale(16'd2, 16'd5, 16'd3);
    long_hold_req = 1'b1;
    run_phase(150);
    // out-of-range scale and width clamp to 99 and full width; tallest image
    set_upscale(16'h00FF, 16'h07FF, 16'hFFFF);
    run_phase(40);
    // pad 3, limits lowered under a busy row
    set_upscale(16'd1, 16'd3, 16'd1);
    run_phase(40);
    set_upscale(16'd4, 16'd1, 16'd4);
    run_phase(60);
    for (int k = 0; k < 4; k++) begin
      set_upscale(16'($urandom_range(1, 4)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 4)));
      run_phase(15);
    end

    settle();
    $display("Sent %0d words over %0d register settings; checked %0d pixels, %0d image ends",
             words_sent, settings_used, pixels_checked, image_ends);
    if (mismatches == 0 && pending_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
design/bmu_pkg.sv
design/bmu_in_if.sv
design/bmu_out_if.sv
design/bmu_cfg_if.sv
design/bmu_line_buf.sv
design/bitmap_integer_upscale.sv
sim/bmu_upscale_checker.sv
sim/bitmap_integer_upscale_tb.sv
